@@ src/wsp_pkg.sv @@
// Shared constants, types and register codes for the wheel speed sync PID core.
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int SUM_BITS_DEF   = 40;

    localparam int GAIN_BITS      = 32;
    localparam int SPEED_BITS     = 16;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 32;

    // Operand magnitudes are clamped to 2^(TERM_SHIFT+TERM_BITS-1); any nonzero gain
    // then already drives its term to the cap, so nothing downstream changes.
    localparam int TERM_SHIFT     = 17;
    localparam int TERM_BITS      = 18;
    localparam int MAG_BITS       = TERM_SHIFT + TERM_BITS;
    localparam int TOTAL_BITS     = TERM_BITS + 2;
    localparam int DRIVE_EXT_BITS = TOTAL_BITS + 2;

    localparam logic [MAG_BITS-1:0]  MAG_CAP  = {1'b1, {(MAG_BITS-1){1'b0}}};
    localparam logic [TERM_BITS-1:0] TERM_CAP = {1'b1, {(TERM_BITS-1){1'b0}}};

    localparam logic [GAIN_BITS-1:0]         PROP_GAIN_RST  = 32'd2619930;
    localparam logic [GAIN_BITS-1:0]         INTEG_GAIN_RST = 32'd4295;
    localparam logic [GAIN_BITS-1:0]         DERIV_GAIN_RST = 32'd68719;
    localparam logic signed [SPEED_BITS-1:0] BASE_SPEED_RST = 16'sd9830;

    localparam logic signed [SPEED_BITS-1:0] DRIVE_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_BITS-1:0] DRIVE_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PROP_GAIN  = 8'd0,
        CFG_INTEG_GAIN = 8'd1,
        CFG_DERIV_GAIN = 8'd2,
        CFG_BASE_SPEED = 8'd3
    } wsp_cfg_idx_t;

    // Operands handed from the error stage to the multipliers.
    typedef struct packed {
        logic                err_pos;
        logic                err_neg;
        logic [MAG_BITS-1:0] err_mag;
        logic [MAG_BITS-1:0] sum_mag;
        logic [MAG_BITS-1:0] diff_mag;
    } wsp_ops_t;

endpackage

`default_nettype wire

@@ src/wheel_sync_pid_core.sv @@
// Top level of the wheel speed sync PID core: handshakes, configuration and pipeline.
//
//  Channel   Handshake                  Payload
//  s_        s_valid / s_ready          s_left_count, s_right_count (signed counts)
//  m_        m_valid / m_ready          m_left_drive, m_right_drive (signed Q1.15)
//  cfg_      cfg_valid / cfg_ready      cfg_index, cfg_data (cfg_ready is always high)
//
//  One item per cycle is sustained while m_ready is high; m_valid marks the output register.
//  The stages are input register, error and sum update, partial products, capped terms
//  and the output register; only the error sum and last error feed back, within one stage.
//  Each stage stalls only when it holds an item and the next one cannot take it.
//  Reset (aresetn low, synchronous) empties the pipeline and restores gains and state.
`timescale 1ns / 1ps
`default_nettype none

module wheel_sync_pid_core #(
    parameter int COUNT_BITS = wsp_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = wsp_pkg::SUM_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic signed [COUNT_BITS-1:0]             s_left_count,
    input  wire logic signed [COUNT_BITS-1:0]             s_right_count,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic signed      [wsp_pkg::SPEED_BITS-1:0]    m_left_drive,
    output logic signed      [wsp_pkg::SPEED_BITS-1:0]    m_right_drive,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic        [wsp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic        [wsp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import wsp_pkg::*;

    logic [GAIN_BITS-1:0]         prop_gain_reg;
    logic [GAIN_BITS-1:0]         integ_gain_reg;
    logic [GAIN_BITS-1:0]         deriv_gain_reg;
    logic signed [SPEED_BITS-1:0] base_speed_reg;

    logic signed [COUNT_BITS-1:0] left_count_reg;
    logic signed [COUNT_BITS-1:0] right_count_reg;

    logic in_valid_reg, ops_valid_reg, prod_valid_reg, term_valid_reg, out_valid_reg;
    logic ops_ready, prod_ready, term_ready, out_ready;
    logic ops_load, prod_load, term_load, out_load;

    logic prod_pos_reg, prod_neg_reg, term_pos_reg, term_neg_reg;

    wsp_ops_t             ops;
    logic [TERM_BITS-1:0] p_term, i_term, d_term;

    // Ready runs backward: a stage takes a transfer when empty or when it drains.
    always_comb begin
        out_ready  = !out_valid_reg  || m_ready;
        term_ready = !term_valid_reg || out_ready;
        prod_ready = !prod_valid_reg || term_ready;
        ops_ready  = !ops_valid_reg  || prod_ready;
        s_ready    = !in_valid_reg   || ops_ready;
        ops_load   = ops_ready  && in_valid_reg;
        prod_load  = prod_ready && ops_valid_reg;
        term_load  = term_ready && prod_valid_reg;
        out_load   = out_ready  && term_valid_reg;
        cfg_ready  = 1'b1;
        m_valid    = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            base_speed_reg <= BASE_SPEED_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PROP_GAIN: begin
                    prop_gain_reg <= cfg_data[GAIN_BITS-1:0];
                end
                CFG_INTEG_GAIN: begin
                    integ_gain_reg <= cfg_data[GAIN_BITS-1:0];
                end
                CFG_DERIV_GAIN: begin
                    deriv_gain_reg <= cfg_data[GAIN_BITS-1:0];
                end
                CFG_BASE_SPEED: begin
                    base_speed_reg <= $signed(cfg_data[SPEED_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            ops_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_ready)    in_valid_reg   <= s_valid;
            if (ops_ready)  ops_valid_reg  <= in_valid_reg;
            if (prod_ready) prod_valid_reg <= ops_valid_reg;
            if (term_ready) term_valid_reg <= prod_valid_reg;
            if (out_ready)  out_valid_reg  <= term_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            left_count_reg  <= s_left_count;
            right_count_reg <= s_right_count;
        end
        if (prod_load) begin
            prod_pos_reg <= ops.err_pos;
            prod_neg_reg <= ops.err_neg;
        end
        if (term_load) begin
            term_pos_reg <= prod_pos_reg;
            term_neg_reg <= prod_neg_reg;
        end
    end

    wsp_err_stage #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_err_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (ops_load),
        .left_count  (left_count_reg),
        .right_count (right_count_reg),
        .ops_reg     (ops)
    );

    wsp_term u_p_term (
        .aclk      (aclk),
        .prod_load (prod_load),
        .term_load (term_load),
        .gain      (prop_gain_reg),
        .operand   (ops.err_mag),
        .term_reg  (p_term)
    );

    wsp_term u_i_term (
        .aclk      (aclk),
        .prod_load (prod_load),
        .term_load (term_load),
        .gain      (integ_gain_reg),
        .operand   (ops.sum_mag),
        .term_reg  (i_term)
    );

    wsp_term u_d_term (
        .aclk      (aclk),
        .prod_load (prod_load),
        .term_load (term_load),
        .gain      (deriv_gain_reg),
        .operand   (ops.diff_mag),
        .term_reg  (d_term)
    );

    wsp_drive u_drive (
        .aclk            (aclk),
        .load            (out_load),
        .err_pos         (term_pos_reg),
        .err_neg         (term_neg_reg),
        .p_term          (p_term),
        .i_term          (i_term),
        .d_term          (d_term),
        .base_speed      (base_speed_reg),
        .left_drive_reg  (m_left_drive),
        .right_drive_reg (m_right_drive)
    );

    // The integrator state moves only when an item enters the error stage.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ops_load |=> $stable(u_err_stage.error_sum_reg) &&
                      $stable(u_err_stage.last_error_reg))
        else $error("PID state changed without an item entering the error stage");

    a_zero_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !term_pos_reg && !term_neg_reg
            |=> m_left_drive == $past(base_speed_reg))
        else $error("Zero error did not yield the base speed");

    a_pos_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && term_pos_reg |=> m_left_drive >= $past(base_speed_reg))
        else $error("Positive error lowered the left drive");

    a_neg_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && term_neg_reg |=> m_left_drive <= $past(base_speed_reg))
        else $error("Negative error raised the left drive");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && ops_valid_reg && out_valid_reg && !m_ready)
        else $error("Input stalled while the pipeline had room");

endmodule

`default_nettype wire

@@ src/wsp_err_stage.sv @@
// Error, saturating error sum, derivative difference and their clamped magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module wsp_err_stage #(
    parameter int COUNT_BITS = wsp_pkg::COUNT_BITS_DEF,
    parameter int SUM_BITS   = wsp_pkg::SUM_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire logic signed [COUNT_BITS-1:0] left_count,
    input  wire logic signed [COUNT_BITS-1:0] right_count,
    output wsp_pkg::wsp_ops_t                 ops_reg
);
    import wsp_pkg::*;

    localparam int ERR_BITS  = COUNT_BITS + 1;
    localparam int DIFF_BITS = COUNT_BITS + 2;
    localparam int ACC_BITS  = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;
    localparam int SMAG_BITS = (SUM_BITS > MAG_BITS) ? SUM_BITS : MAG_BITS;

    localparam logic signed [ACC_BITS-1:0] SUM_MAX =
        {{(ACC_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SUM_MIN =
        {{(ACC_BITS-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};
    localparam logic [SMAG_BITS-1:0] SUM_MAG_CAP = SMAG_BITS'(MAG_CAP);

    logic signed [SUM_BITS-1:0] error_sum_reg;
    logic signed [SUM_BITS-1:0] error_sum_next;
    logic signed [ERR_BITS-1:0] last_error_reg;

    logic [COUNT_BITS-1:0]       left_mag;
    logic [COUNT_BITS-1:0]       right_mag;
    logic signed [ERR_BITS-1:0]  err;
    logic [ERR_BITS-1:0]         err_abs;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        diff_abs;
    logic [SUM_BITS-1:0]         sum_abs;
    logic [SMAG_BITS-1:0]        sum_abs_ext;
    wsp_ops_t                    ops_next;

    always_comb begin
        // The most negative count has a magnitude that still fits unsigned.
        left_mag  = left_count[COUNT_BITS-1]  ? -left_count  : left_count;
        right_mag = right_count[COUNT_BITS-1] ? -right_count : right_count;
        err       = $signed({1'b0, right_mag}) - $signed({1'b0, left_mag});
        err_abs   = err[ERR_BITS-1] ? -err : err;

        acc = ACC_BITS'(error_sum_reg) + ACC_BITS'(err);
        if (acc > SUM_MAX) begin
            error_sum_next = SUM_MAX[SUM_BITS-1:0];
        end else if (acc < SUM_MIN) begin
            error_sum_next = SUM_MIN[SUM_BITS-1:0];
        end else begin
            error_sum_next = acc[SUM_BITS-1:0];
        end

        diff     = DIFF_BITS'(err) - DIFF_BITS'(last_error_reg);
        diff_abs = diff[DIFF_BITS-1] ? -diff : diff;

        sum_abs     = error_sum_next[SUM_BITS-1] ? -error_sum_next : error_sum_next;
        sum_abs_ext = SMAG_BITS'(sum_abs);

        ops_next.err_pos  = !err[ERR_BITS-1] && (err != '0);
        ops_next.err_neg  = err[ERR_BITS-1];
        ops_next.err_mag  = MAG_BITS'(err_abs);
        ops_next.diff_mag = MAG_BITS'(diff_abs);
        ops_next.sum_mag  = (sum_abs_ext > SUM_MAG_CAP) ? MAG_CAP
                                                         : sum_abs_ext[MAG_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (load) begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ops_reg <= ops_next;
        end
    end

endmodule

`default_nettype wire

@@ src/wsp_term.sv @@
// One gain term: registered partial products, then the shifted and capped term.
`timescale 1ns / 1ps
`default_nettype none

module wsp_term (
    input  wire logic                          aclk,
    input  wire logic                          prod_load,
    input  wire logic                          term_load,
    input  wire logic [wsp_pkg::GAIN_BITS-1:0] gain,
    input  wire logic [wsp_pkg::MAG_BITS-1:0]  operand,
    output logic      [wsp_pkg::TERM_BITS-1:0] term_reg
);
    import wsp_pkg::*;

    localparam int HI_BITS   = MAG_BITS - GAIN_BITS;
    localparam int PROD_BITS = MAG_BITS + GAIN_BITS;

    logic [2*GAIN_BITS-1:0]       prod_lo_reg;
    logic [GAIN_BITS+HI_BITS-1:0] prod_hi_reg;
    logic [PROD_BITS-1:0]         prod_full;
    logic [PROD_BITS-1:0]         prod_shift;
    logic [TERM_BITS-1:0]         term_next;

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_lo_reg <= gain * operand[GAIN_BITS-1:0];
            prod_hi_reg <= gain * operand[MAG_BITS-1:GAIN_BITS];
        end
    end

    always_comb begin
        prod_full  = {prod_hi_reg, {GAIN_BITS{1'b0}}} + PROD_BITS'(prod_lo_reg);
        prod_shift = prod_full >> TERM_SHIFT;
        // Anything at or above the cap saturates the drive anyway.
        term_next  = (|prod_shift[PROD_BITS-1:TERM_BITS-1]) ? TERM_CAP
                                                            : prod_shift[TERM_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (term_load) begin
            term_reg <= term_next;
        end
    end

endmodule

`default_nettype wire

@@ src/wsp_drive.sv @@
// Sums the three terms, applies them around the base speed and saturates the drive.
`timescale 1ns / 1ps
`default_nettype none

module wsp_drive (
    input  wire logic                                  aclk,
    input  wire logic                                  load,
    input  wire logic                                  err_pos,
    input  wire logic                                  err_neg,
    input  wire logic        [wsp_pkg::TERM_BITS-1:0]  p_term,
    input  wire logic        [wsp_pkg::TERM_BITS-1:0]  i_term,
    input  wire logic        [wsp_pkg::TERM_BITS-1:0]  d_term,
    input  wire logic signed [wsp_pkg::SPEED_BITS-1:0] base_speed,
    output logic signed      [wsp_pkg::SPEED_BITS-1:0] left_drive_reg,
    output logic signed      [wsp_pkg::SPEED_BITS-1:0] right_drive_reg
);
    import wsp_pkg::*;

    logic [TOTAL_BITS-1:0]            total;
    logic signed [DRIVE_EXT_BITS-1:0] base_ext;
    logic signed [DRIVE_EXT_BITS-1:0] total_ext;
    logic signed [DRIVE_EXT_BITS-1:0] drive_ext;
    logic signed [SPEED_BITS-1:0]     left_drive_next;

    always_comb begin
        total     = TOTAL_BITS'(p_term) + TOTAL_BITS'(i_term) + TOTAL_BITS'(d_term);
        base_ext  = DRIVE_EXT_BITS'(base_speed);
        total_ext = $signed(DRIVE_EXT_BITS'(total));
        priority if (err_pos) begin
            drive_ext = base_ext + total_ext;
        end else if (err_neg) begin
            drive_ext = base_ext - total_ext;
        end else begin
            drive_ext = base_ext;
        end
        if (drive_ext > DRIVE_EXT_BITS'(DRIVE_MAX)) begin
            left_drive_next = DRIVE_MAX;
        end else if (drive_ext < DRIVE_EXT_BITS'(DRIVE_MIN)) begin
            left_drive_next = DRIVE_MIN;
        end else begin
            left_drive_next = drive_ext[SPEED_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= base_speed;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/wheel_sync_pid_core_tb.sv @@
// Self-checking testbench for the wheel speed sync PID core with a built-in drive predictor.
`timescale 1ns / 1ps

module wheel_sync_pid_core_tb;

    import wsp_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int SUM_BITS   = SUM_BITS_DEF;
    localparam int COUNT_MAX  = (1 << (COUNT_BITS - 1)) - 1;

    localparam logic signed [COUNT_BITS-1:0] CNT_MIN = 24'sh800000;
    localparam logic signed [COUNT_BITS-1:0] CNT_TOP = 24'sh7FFFFF;
    localparam logic signed [COUNT_BITS-1:0] CNT_LOW = 24'sh800001;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOP   = 8'hFF;

    localparam int     PID_SHIFT    = 17;
    localparam longint PID_TERM_MAX = 64'sd1 <<< 20;
    localparam int     SOAK_ITEMS   = 24;
    localparam int     TIMEOUT_NS   = 4_000_000;
    localparam int     MAX_PRINTS   = 40;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] left_drive;
        logic signed [SPEED_BITS-1:0] right_drive;
    } drive_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [CFG_IDX_BITS-1:0]      idx;
        logic [CFG_DATA_BITS-1:0]     data;
        logic signed [COUNT_BITS-1:0] left_c;
        logic signed [COUNT_BITS-1:0] right_c;
        logic                         known;
        logic signed [SPEED_BITS-1:0] exp_left;
        logic signed [SPEED_BITS-1:0] exp_right;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    // Rows with known set carry a drive that follows directly from the gains and base speed.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd0, 24'sd0, 1'b1, BASE_SPEED_RST, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd0, 24'sd1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, -24'sd1, 24'sd1, 1'b1, BASE_SPEED_RST, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd0, CNT_MIN, 1'b1, DRIVE_MAX, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, CNT_MIN, 24'sd0, 1'b1, DRIVE_MIN, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, CNT_TOP, CNT_LOW, 1'b1, BASE_SPEED_RST, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, CNT_MIN, CNT_MIN, 1'b1, BASE_SPEED_RST, BASE_SPEED_RST},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd100, 24'sd37, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, CNT_TOP, 24'sd8388606, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_PROP_GAIN, 32'd0, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_INTEG_GAIN, 32'd0, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_DERIV_GAIN, 32'd0, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_BASE_SPEED, 32'h0000_7FFF, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd0, CNT_MIN, 1'b1, DRIVE_MAX, DRIVE_MAX},
        '{ROW_REG, CFG_BASE_SPEED, 32'hABCD_8000, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, CNT_MIN, CNT_TOP, 1'b1, DRIVE_MIN, DRIVE_MIN},
        '{ROW_REG, CFG_IDX_SPARE, 32'd0, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_IDX_TOP, 32'h0000_7FFF, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd5, 24'sd3, 1'b1, DRIVE_MIN, DRIVE_MIN},
        '{ROW_REG, CFG_PROP_GAIN, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_INTEG_GAIN, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_DERIV_GAIN, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_REG, CFG_BASE_SPEED, 32'h5A5A_0000, 24'sd0, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd0, 24'sd1, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_PROP_GAIN, 32'd0, 24'sd7, -24'sd7, 1'b1, 16'sd0, 16'sd0}
    };

    logic                         aclk;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic signed [COUNT_BITS-1:0] s_left_count  = '0;
    logic signed [COUNT_BITS-1:0] s_right_count = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic signed [SPEED_BITS-1:0] m_left_drive;
    logic signed [SPEED_BITS-1:0] m_right_drive;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data      = '0;

    // Predictor copy of the registers and loop state.
    logic [GAIN_BITS-1:0]         gain_p   = PROP_GAIN_RST;
    logic [GAIN_BITS-1:0]         gain_i   = INTEG_GAIN_RST;
    logic [GAIN_BITS-1:0]         gain_d   = DERIV_GAIN_RST;
    logic signed [SPEED_BITS-1:0] base_spd = BASE_SPEED_RST;
    logic signed [SUM_BITS-1:0]   err_sum  = '0;
    logic signed [COUNT_BITS:0]   last_err = '0;

    drive_t drive_q [$];

    int  items_sent      = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  mismatch_cnt    = 0;
    int  hold_cnt        = 0;
    bit  idle_en         = 1'b0;

    wheel_sync_pid_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_left_count  (s_left_count),
        .s_right_count (s_right_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_drive  (m_left_drive),
        .m_right_drive (m_right_drive),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] mag_of(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // One PID term: Q0.32 gain times an integer magnitude, moved to Q1.15 and capped.
    function automatic longint pid_term(input logic [GAIN_BITS-1:0] gain, input logic [63:0] m);
        logic [95:0] g_w;
        logic [95:0] m_w;
        logic [95:0] prod;
        g_w  = 96'(gain);
        m_w  = 96'(m);
        prod = (g_w * m_w) >> PID_SHIFT;
        if (prod > PID_TERM_MAX)
            return PID_TERM_MAX;
        return prod[63:0];
    endfunction

    function automatic drive_t predict_drive(input logic signed [COUNT_BITS-1:0] left_c,
                                             input logic signed [COUNT_BITS-1:0] right_c);
        longint lmag, rmag, err, sum, diff, total, drv, smax, smin;
        drive_t d;
        lmag = longint'(left_c);
        rmag = longint'(right_c);
        if (lmag < 0) lmag = -lmag;
        if (rmag < 0) rmag = -rmag;
        err  = rmag - lmag;
        smax = (64'sd1 <<< (SUM_BITS - 1)) - 1;
        smin = -smax - 1;
        sum  = longint'(err_sum);
        if (err > 0 && sum > smax - err)
            sum = smax;
        else if (err < 0 && sum < smin - err)
            sum = smin;
        else
            sum = sum + err;
        err_sum  = sum[SUM_BITS-1:0];
        diff     = err - longint'(last_err);
        last_err = err[COUNT_BITS:0];
        total = pid_term(gain_p, mag_of(err)) + pid_term(gain_i, mag_of(sum))
              + pid_term(gain_d, mag_of(diff));
        if (err > 0)
            drv = longint'(base_spd) + total;
        else if (err < 0)
            drv = longint'(base_spd) - total;
        else
            drv = longint'(base_spd);
        if (drv > longint'(DRIVE_MAX)) drv = longint'(DRIVE_MAX);
        if (drv < longint'(DRIVE_MIN)) drv = longint'(DRIVE_MIN);
        d.left_drive  = drv[SPEED_BITS-1:0];
        d.right_drive = base_spd;
        return d;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_PROP_GAIN:  gain_p   = data;
            CFG_INTEG_GAIN: gain_i   = data;
            CFG_DERIV_GAIN: gain_d   = data;
            CFG_BASE_SPEED: base_spd = data[SPEED_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [COUNT_BITS-1:0] corner_count();
        case ($urandom_range(0, 4))
            0: return CNT_MIN;
            1: return CNT_TOP;
            2: return CNT_LOW;
            3: return '0;
            default: return COUNT_BITS'($urandom_range(0, 3));
        endcase
    endfunction

    // Mostly counts that track each other closely, so the drive stays out of saturation.
    function automatic void pick_counts(output logic signed [COUNT_BITS-1:0] lc,
                                        output logic signed [COUNT_BITS-1:0] rc);
        int mode, lmag, rmag, delta, lsmall, rsmall;
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            lmag  = $urandom_range(0, COUNT_MAX) >> $urandom_range(0, COUNT_BITS - 1);
            delta = $urandom_range(0, 4000);
            delta = (mode == 5) ? 0 : delta - 2000;
            rmag  = lmag + delta;
            if (rmag < 0) rmag = 0;
            if (rmag > COUNT_MAX) rmag = COUNT_MAX;
            lc = COUNT_BITS'($urandom_range(0, 1) ? -lmag : lmag);
            rc = COUNT_BITS'($urandom_range(0, 1) ? -rmag : rmag);
        end else if (mode <= 7) begin
            lc = COUNT_BITS'($urandom);
            rc = COUNT_BITS'($urandom);
        end else if (mode == 8) begin
            lsmall = $urandom_range(0, 127);
            rsmall = $urandom_range(0, 127);
            lc = COUNT_BITS'(lsmall - 64);
            rc = COUNT_BITS'(rsmall - 64);
        end else begin
            lc = corner_count();
            rc = $urandom_range(0, 1) ? corner_count() : COUNT_BITS'($urandom);
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        if (mismatch_cnt < MAX_PRINTS)
            $display("[%0t] mismatch on %s after %0d results: expected %0d, got %0d",
                     $realtime, what, results_checked, exp_v, got_v);
        mismatch_cnt++;
    endtask

    task automatic send_item(input logic signed [COUNT_BITS-1:0] lc,
                             input logic signed [COUNT_BITS-1:0] rc,
                             input logic known,
                             input logic signed [SPEED_BITS-1:0] el,
                             input logic signed [SPEED_BITS-1:0] er);
        drive_t d;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_left_count  <= lc;
        s_right_count <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        d = predict_drive(lc, rc);
        if (known) begin
            d.left_drive  = el;
            d.right_drive = er;
        end
        drive_q.push_back(d);
        items_sent++;
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no extra step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
    endtask

    task automatic load_regs(input logic [GAIN_BITS-1:0] p, input logic [GAIN_BITS-1:0] i,
                             input logic [GAIN_BITS-1:0] d, input logic [SPEED_BITS-1:0] b);
        logic [15:0]             junk;
        logic [CFG_IDX_BITS-1:0] spare;
        junk  = 16'($urandom);
        spare = CFG_IDX_BITS'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP));
        wait_drained();
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_BASE_SPEED, {junk, b});
        if ($urandom_range(0, 1))
            write_reg(spare, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input bit quiet);
        logic signed [COUNT_BITS-1:0] lc, rc;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0)
                idle_en = quiet ? 1'b0 : ($urandom_range(0, 2) != 0);
            if (!quiet && k != 0 && $urandom_range(0, 199) == 0)
                wait_drained();
            pick_counts(lc, rc);
            send_item(lc, rc, 1'b0, '0, '0);
        end
    endtask

    // Result side: random stall bursts while idling is enabled.
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            hold_cnt <= $urandom_range(0, 18);
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        drive_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            if (drive_q.size() == 0) begin
                report_mismatch("unexpected result transfer", 0, m_left_drive);
            end else begin
                exp_d = drive_q.pop_front();
                if (m_left_drive !== exp_d.left_drive)
                    report_mismatch("left_drive", exp_d.left_drive, m_left_drive);
                if (m_right_drive !== exp_d.right_drive)
                    report_mismatch("right_drive", exp_d.right_drive, m_right_drive);
            end
            results_checked++;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected.", drive_q.size());
        $display("FAIL wheel_sync_pid_core");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_en = 1'b1;
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].kind == ROW_REG) begin
                wait_drained();
                write_reg(dir_tab[k].idx, dir_tab[k].data);
                if (k == DIR_ROWS - 1 || dir_tab[k + 1].kind != ROW_REG)
                    cfg_valid <= 1'b0;
            end else begin
                send_item(dir_tab[k].left_c, dir_tab[k].right_c, dir_tab[k].known,
                          dir_tab[k].exp_left, dir_tab[k].exp_right);
            end
        end

        // Push the error sum far out in both directions under a unit integral gain, so
        // the integral term alone moves the drive, then bring it back through zero.
        idle_en = 1'b0;
        load_regs(32'd0, 32'd1, 32'd0, 16'd0);
        for (int k = 0; k < SOAK_ITEMS; k++)
            send_item(24'sd0, CNT_MIN, 1'b0, '0, '0);
        for (int k = 0; k < 2 * SOAK_ITEMS; k++)
            send_item(CNT_MIN, 24'sd0, 1'b0, '0, '0);
        for (int k = 0; k < SOAK_ITEMS; k++)
            send_item(24'sd0, CNT_MIN, 1'b0, '0, '0);
        for (int k = 0; k < 8; k++)
            send_item(24'sd3, -24'sd2, 1'b0, '0, '0);

        load_regs(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, BASE_SPEED_RST);
        run_phase(250, 1'b0);
        load_regs($urandom_range(0, 1 << 23), $urandom_range(0, 1 << 16),
                  $urandom_range(0, 1 << 20), SPEED_BITS'($urandom));
        run_phase(250, 1'b0);
        load_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, DRIVE_MIN);
        run_phase(250, 1'b0);
        load_regs(32'd0, 32'hFFFF_FFFF, 32'd0, DRIVE_MAX);
        run_phase(250, 1'b0);
        load_regs($urandom, $urandom, $urandom, SPEED_BITS'($urandom));
        run_phase(250, 1'b0);
        load_regs($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 12),
                  $urandom_range(0, 1 << 18), SPEED_BITS'($urandom));
        run_phase(250, 1'b1);

        wait_drained();
        repeat (12) @(posedge aclk);

        $display("Sent %0d count pairs, checked %0d drive results, made %0d register writes.",
                 items_sent, results_checked, reg_writes);
        $display("Covered count extremes, gain and base limits, ignored indexes and %s",
                 "long integral runs in both directions.");
        if (mismatch_cnt == 0 && drive_q.size() == 0) begin
            $display("PASS wheel_sync_pid_core");
        end else begin
            $display("%0d mismatches, %0d results missing.", mismatch_cnt, drive_q.size());
            $display("FAIL wheel_sync_pid_core");
        end
        $finish;
    end

endmodule
